// ----- hdl/pss_pkg.sv -----
// ----------------------------------------------------------------------------
// Palette slot swap search package
// Shared types, codes and saturating helpers for the slot search block.
// ----------------------------------------------------------------------------
package pss_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_SR_RD,
        ST_SR_CHK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PIX,
        ST_RED,
        ST_DONE
    } pss_state_t;

    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_PIXEL   = 1'b1;

    localparam logic [1:0] COMP_L = 2'd0;
    localparam logic [1:0] COMP_A = 2'd1;
    localparam logic [1:0] COMP_B = 2'd2;

    localparam logic [31:0] MIN_WEIGHT = 32'd17;
    localparam logic signed [62:0] RED_MAX = 63'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [62:0] RED_MIN = {1'b1, 62'h0};
    localparam logic signed [62:0] START_THRESHOLD = 63'sh7FFF_FC00_0000_0000;

    typedef struct packed {
        logic signed [47:0] sum_l;
        logic signed [47:0] sum_a;
        logic signed [47:0] sum_b;
        logic [63:0]        sum_err;
        logic [31:0]        sum_w;
    } acc_entry_t;

    typedef struct packed {
        logic signed [15:0] l;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic [15:0]        w;
        logic [7:0]         slot;
    } pix_entry_t;

    typedef struct packed {
        logic               ovf;
        logic signed [47:0] val;
    } sat48_t;

    typedef struct packed {
        logic        ovf;
        logic [63:0] val;
    } sat64_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] quotient;
    } div_res_t;

    function automatic sat48_t add48(input logic signed [47:0] a,
                                     input logic signed [32:0] b);
        logic signed [48:0] s;
        sat48_t r;
        s = {a[47], a} + 49'(b);
        r.ovf = (s[48] != s[47]);
        if (!r.ovf) begin
            r.val = s[47:0];
        end else if (s[48]) begin
            r.val = {1'b1, 47'h0};
        end else begin
            r.val = {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

    function automatic sat64_t add64u(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        sat64_t r;
        s = {1'b0, a} + {1'b0, b};
        r.ovf = s[64];
        r.val = s[64] ? {64{1'b1}} : s[63:0];
        return r;
    endfunction

endpackage

// ----- hdl/pss_div.sv -----
// ----------------------------------------------------------------------------
// Centroid divider
// Restoring signed-by-unsigned division, one quotient bit per cycle,
// truncating toward zero and clamping the result to 16 signed bits.
// ----------------------------------------------------------------------------
module pss_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [47:0]        dividend,
    input  logic [31:0]               divisor,
    output pss_pkg::div_res_t         res
);
    import pss_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [47:0] quo_reg;
    logic [31:0] dvs_reg;
    logic        neg_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, quo_reg[47]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd48;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend[47] ? 48'(-dividend) : 48'(dividend);
            dvs_reg <= divisor;
            neg_reg <= dividend[47];
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= 32'(trial - {1'b0, dvs_reg});
                quo_reg <= {quo_reg[46:0], 1'b1};
            end else begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[46:0], 1'b0};
            end
        end
    end

    always_comb begin
        res.done = done_reg;
        if (neg_reg) begin
            if (quo_reg > 48'd32768) begin
                res.quotient = 16'sh8000;
            end else begin
                res.quotient = 16'(-quo_reg[15:0]);
            end
        end else begin
            if (quo_reg > 48'd32767) begin
                res.quotient = 16'sh7FFF;
            end else begin
                res.quotient = quo_reg[15:0];
            end
        end
    end

endmodule

// ----- hdl/palette_slot_swap_search.sv -----
// ----------------------------------------------------------------------------
// Palette slot swap search
// One weighted k-means update step over an OKLab palette, picking the slot
// whose centroid move reduces the cluster error the most.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the s_ channel. A request with s_cmd = 0 writes a
// palette entry and its exclude mark. A request with s_cmd = 1 is a pixel:
// it is compared with each active palette entry through one shared distance
// unit, one entry per cycle. The pixel marked s_last then runs the search: for
// each qualifying slot three divisions form the centroid and all stored pixels
// are scanned, one per cycle, those of that slot being re-measured. Exactly
// one result leaves on the m_ channel per last pixel. s_ready is high only
// while the block is idle. The result sits in an output register, so the
// block takes new requests while the receiver stalls; only a second result
// waits for the first to go. Reset clears the accumulators through per-slot
// valid bits at once, sets color_count to 256 and needs no clearing pass. The
// palette and pixel memories hold whatever was last written. cfg_ready is
// always high.
// ----------------------------------------------------------------------------
module palette_slot_swap_search #(
    parameter int MAX_COLORS = 256,
    parameter int MAX_PIXELS = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [7:0]         s_slot,
    input  logic signed [15:0] s_comp_l,
    input  logic signed [15:0] s_comp_a,
    input  logic signed [15:0] s_comp_b,
    input  logic               s_excluded,
    input  logic [15:0]        s_row_weight,
    input  logic [15:0]        s_column_weight,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_best_slot,
    output logic               m_found,
    output logic signed [15:0] m_centroid_l,
    output logic signed [15:0] m_centroid_a,
    output logic signed [15:0] m_centroid_b,
    output logic signed [62:0] m_error_reduction,
    output logic               m_overflow,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [8:0]         cfg_data
);
    import pss_pkg::*;

    localparam int CW = $clog2(MAX_COLORS);
    localparam int PW = $clog2(MAX_PIXELS);

    pss_state_t state_reg, state_next;

    // Storage. Accumulators are qualified by per-slot valid bits.
    logic [47:0]  pal_mem [MAX_COLORS];
    logic         excl_mem [MAX_COLORS];
    pix_entry_t   pix_mem [MAX_PIXELS];
    acc_entry_t   acc_mem [MAX_COLORS];
    logic [MAX_COLORS-1:0] acc_vld_reg;

    logic [8:0]   cc_reg;
    logic [CW:0]  n_act;
    logic         s_acc;

    logic signed [15:0] pix_l_reg, pix_a_reg, pix_b_reg;
    logic         last_reg;
    logic [15:0]  wgt_reg;
    logic [PW:0]  count_reg;
    logic         ovf_reg;

    // Nearest-entry scan.
    logic [CW:0]   scan_k_reg;
    logic          s1_vld_reg, s2_vld_reg;
    logic [CW-1:0] s1_idx_reg, s2_idx_reg;
    logic [33:0]   dist_reg, bd_reg;
    logic [CW-1:0] best_reg;
    logic [47:0]   pal_q_reg;
    logic          excl_q_reg;

    // Accumulate.
    acc_entry_t    acc_q_reg, acc_cur, sr_acc_reg;
    logic          acc_v_q_reg;
    logic signed [32:0] prod_l_reg, prod_a_reg, prod_b_reg;
    logic [49:0]   eprod_reg;

    // Search.
    logic [CW:0]   sk_reg;
    logic [1:0]    div_sel_reg;
    logic signed [15:0] cen_l_reg, cen_a_reg, cen_b_reg;
    logic [PW:0]   pp_reg;
    pix_entry_t    pixq_reg;
    logic          p1_vld_reg, p2_vld_reg, p3_vld_reg;
    logic [15:0]   p2_w_reg;
    logic [63:0]   ne_reg;
    logic signed [62:0] bred_reg;
    logic [CW-1:0] bslot_reg;
    logic          found_reg;
    logic signed [15:0] bc_l_reg, bc_a_reg, bc_b_reg;

    // Output register.
    logic               m_valid_reg;
    logic [7:0]         m_best_slot_reg;
    logic               m_found_reg;
    logic signed [15:0] m_cen_l_reg, m_cen_a_reg, m_cen_b_reg;
    logic signed [62:0] m_red_reg;
    logic               m_ovf_reg;

    logic [CW-1:0] pal_addr, acc_addr;
    logic          scan_done, pix_done, qualifies;
    logic [31:0]   wprod;
    logic [15:0]   w_sat;

    // Shared distance unit and shared error multiplier.
    logic signed [15:0] dp_l, dp_a, dp_b, dq_l, dq_a, dq_b;
    logic signed [16:0] d_l, d_a, d_b;
    logic signed [33:0] sq_l, sq_a, sq_b;
    logic [33:0]        dist_calc;
    logic [33:0]        em_a;
    logic [15:0]        em_b;
    logic [49:0]        em_prod;
    logic signed [16:0] wgt_s;

    sat48_t  nl, na, nb;
    sat64_t  nerr, ne_add;
    logic [32:0] nw;
    logic [63:0] dd;
    logic signed [62:0] red_calc;
    logic        red_ovf;

    div_res_t           div_res;
    logic signed [47:0] div_dividend;

    assign s_acc     = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        if (cc_reg == 9'd0) begin
            n_act = (CW+1)'(1);
        end else if (cc_reg > 9'(MAX_COLORS)) begin
            n_act = (CW+1)'(MAX_COLORS);
        end else begin
            n_act = cc_reg[CW:0];
        end
    end

    assign wprod = s_row_weight * s_column_weight;
    assign w_sat = (|wprod[31:30]) ? 16'hFFFF : wprod[29:14];

    assign pal_addr = (state_reg == ST_SCAN) ? scan_k_reg[CW-1:0] : sk_reg[CW-1:0];
    assign acc_addr = (state_reg == ST_ACC_RD) ? best_reg : sk_reg[CW-1:0];
    assign acc_cur  = acc_v_q_reg ? acc_q_reg : '0;

    always_comb begin
        if (state_reg == ST_SCAN) begin
            dp_l = pix_l_reg;
            dp_a = pix_a_reg;
            dp_b = pix_b_reg;
            dq_l = pal_q_reg[47:32];
            dq_a = pal_q_reg[31:16];
            dq_b = pal_q_reg[15:0];
        end else begin
            dp_l = pixq_reg.l;
            dp_a = pixq_reg.a;
            dp_b = pixq_reg.b;
            dq_l = cen_l_reg;
            dq_a = cen_a_reg;
            dq_b = cen_b_reg;
        end
    end

    assign d_l  = 17'(dp_l) - 17'(dq_l);
    assign d_a  = 17'(dp_a) - 17'(dq_a);
    assign d_b  = 17'(dp_b) - 17'(dq_b);
    assign sq_l = d_l * d_l;
    assign sq_a = d_a * d_a;
    assign sq_b = d_b * d_b;
    assign dist_calc = {2'b00, sq_l[31:0]} + {2'b00, sq_a[31:0]} + {2'b00, sq_b[31:0]};

    assign em_a    = (state_reg == ST_ACC_RD) ? bd_reg : dist_reg;
    assign em_b    = (state_reg == ST_ACC_RD) ? wgt_reg : p2_w_reg;
    assign em_prod = 50'(em_a) * 50'(em_b);
    assign wgt_s   = {1'b0, wgt_reg};

    assign nl     = add48(acc_cur.sum_l, prod_l_reg);
    assign na     = add48(acc_cur.sum_a, prod_a_reg);
    assign nb     = add48(acc_cur.sum_b, prod_b_reg);
    assign nerr   = add64u(acc_cur.sum_err, 64'(eprod_reg));
    assign nw     = {1'b0, acc_cur.sum_w} + 33'(wgt_reg);
    assign ne_add = add64u(ne_reg, 64'(eprod_reg));

    assign scan_done = (scan_k_reg == n_act) && !s1_vld_reg && !s2_vld_reg;
    assign pix_done  = (pp_reg == count_reg) && !p1_vld_reg && !p2_vld_reg && !p3_vld_reg;
    assign qualifies = (acc_cur.sum_w >= MIN_WEIGHT) && !excl_q_reg;

    always_comb begin
        red_ovf = 1'b0;
        if (sr_acc_reg.sum_err >= ne_reg) begin
            dd = sr_acc_reg.sum_err - ne_reg;
            if (dd > 64'(RED_MAX)) begin
                red_ovf  = 1'b1;
                red_calc = RED_MAX;
            end else begin
                red_calc = dd[62:0];
            end
        end else begin
            dd = ne_reg - sr_acc_reg.sum_err;
            if (dd > {2'b01, 62'h0}) begin
                red_ovf  = 1'b1;
                red_calc = RED_MIN;
            end else begin
                red_calc = 63'(-dd);
            end
        end
    end

    always_comb begin
        unique case (div_sel_reg)
            COMP_L:  div_dividend = sr_acc_reg.sum_l;
            COMP_A:  div_dividend = sr_acc_reg.sum_a;
            default: div_dividend = sr_acc_reg.sum_b;
        endcase
    end

    pss_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_DIV_GO),
        .dividend (div_dividend),
        .divisor  (sr_acc_reg.sum_w),
        .res      (div_res)
    );

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_cmd == CMD_PIXEL) begin
                    if (count_reg >= (PW+1)'(MAX_PIXELS)) begin
                        state_next = s_last ? ST_SR_RD : ST_IDLE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:     if (scan_done) state_next = ST_ACC_RD;
            ST_ACC_RD:   state_next = ST_ACC_WR;
            ST_ACC_WR:   state_next = last_reg ? ST_SR_RD : ST_IDLE;
            ST_SR_RD:    state_next = (sk_reg >= n_act) ? ST_DONE : ST_SR_CHK;
            ST_SR_CHK:   state_next = qualifies ? ST_DIV_GO : ST_SR_RD;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_res.done) begin
                    state_next = (div_sel_reg == COMP_B) ? ST_PIX : ST_DIV_GO;
                end
            end
            ST_PIX:      if (pix_done) state_next = ST_RED;
            ST_RED:      state_next = ST_SR_RD;
            ST_DONE:     if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Memories.
    always_ff @(posedge aclk) begin
        if (s_acc && s_cmd == CMD_PALETTE && {1'b0, s_slot} < 9'(MAX_COLORS)) begin
            pal_mem[s_slot[CW-1:0]]  <= {s_comp_l, s_comp_a, s_comp_b};
            excl_mem[s_slot[CW-1:0]] <= s_excluded;
        end
        pal_q_reg  <= pal_mem[pal_addr];
        excl_q_reg <= excl_mem[pal_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ACC_RD) begin
            pix_mem[count_reg[PW-1:0]] <= '{l: pix_l_reg, a: pix_a_reg, b: pix_b_reg,
                                            w: wgt_reg, slot: 8'(best_reg)};
        end
        pixq_reg <= pix_mem[pp_reg[PW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ACC_WR) begin
            acc_mem[best_reg] <= '{sum_l: nl.val, sum_a: na.val, sum_b: nb.val,
                                   sum_err: nerr.val,
                                   sum_w: nw[32] ? 32'hFFFF_FFFF : nw[31:0]};
        end
        acc_q_reg   <= acc_mem[acc_addr];
        acc_v_q_reg <= acc_vld_reg[acc_addr];
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg      <= 9'd256;
            acc_vld_reg <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cc_reg <= cfg_data;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    s1_vld_reg <= 1'b0;
                    s2_vld_reg <= 1'b0;
                    if (s_acc && s_cmd == CMD_PIXEL &&
                        count_reg >= (PW+1)'(MAX_PIXELS)) begin
                        ovf_reg <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    s1_vld_reg <= (scan_k_reg < n_act);
                    s2_vld_reg <= s1_vld_reg;
                end
                ST_ACC_WR: begin
                    acc_vld_reg[best_reg] <= 1'b1;
                    count_reg <= count_reg + (PW+1)'(1);
                    if (nl.ovf || na.ovf || nb.ovf || nerr.ovf || nw[32]) begin
                        ovf_reg <= 1'b1;
                    end
                end
                ST_DIV_WAIT: begin
                    p1_vld_reg <= 1'b0;
                    p2_vld_reg <= 1'b0;
                    p3_vld_reg <= 1'b0;
                end
                ST_PIX: begin
                    p1_vld_reg <= (pp_reg < count_reg);
                    p2_vld_reg <= p1_vld_reg && (pixq_reg.slot == 8'(sk_reg[CW-1:0]));
                    p3_vld_reg <= p2_vld_reg;
                    if (p3_vld_reg && ne_add.ovf) begin
                        ovf_reg <= 1'b1;
                    end
                end
                ST_RED: begin
                    if (red_ovf) begin
                        ovf_reg <= 1'b1;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        acc_vld_reg <= '0;
                        count_reg   <= '0;
                        ovf_reg     <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                scan_k_reg <= '0;
                pix_l_reg  <= s_comp_l;
                pix_a_reg  <= s_comp_a;
                pix_b_reg  <= s_comp_b;
                wgt_reg    <= w_sat;
                last_reg   <= s_last;
                sk_reg     <= (CW+1)'(1);
                bred_reg   <= START_THRESHOLD;
                bslot_reg  <= '0;
                found_reg  <= 1'b0;
                bc_l_reg   <= '0;
                bc_a_reg   <= '0;
                bc_b_reg   <= '0;
            end
            ST_SCAN: begin
                if (scan_k_reg < n_act) begin
                    scan_k_reg <= scan_k_reg + (CW+1)'(1);
                end
                s1_idx_reg <= scan_k_reg[CW-1:0];
                s2_idx_reg <= s1_idx_reg;
                dist_reg   <= dist_calc;
                if (s2_vld_reg && (s2_idx_reg == '0 || dist_reg < bd_reg)) begin
                    bd_reg   <= dist_reg;
                    best_reg <= s2_idx_reg;
                end
            end
            ST_ACC_RD: begin
                prod_l_reg <= pix_l_reg * wgt_s;
                prod_a_reg <= pix_a_reg * wgt_s;
                prod_b_reg <= pix_b_reg * wgt_s;
                eprod_reg  <= em_prod;
            end
            ST_SR_CHK: begin
                sr_acc_reg  <= acc_cur;
                div_sel_reg <= COMP_L;
                if (!qualifies) begin
                    sk_reg <= sk_reg + (CW+1)'(1);
                end
            end
            ST_DIV_WAIT: begin
                pp_reg <= '0;
                ne_reg <= '0;
                if (div_res.done) begin
                    unique case (div_sel_reg)
                        COMP_L:  cen_l_reg <= div_res.quotient;
                        COMP_A:  cen_a_reg <= div_res.quotient;
                        default: cen_b_reg <= div_res.quotient;
                    endcase
                    div_sel_reg <= div_sel_reg + 2'd1;
                end
            end
            ST_PIX: begin
                if (pp_reg < count_reg) begin
                    pp_reg <= pp_reg + (PW+1)'(1);
                end
                dist_reg  <= dist_calc;
                p2_w_reg  <= pixq_reg.w;
                eprod_reg <= em_prod;
                if (p3_vld_reg) begin
                    ne_reg <= ne_add.val;
                end
            end
            ST_RED: begin
                sk_reg <= sk_reg + (CW+1)'(1);
                if (red_calc > bred_reg) begin
                    bred_reg  <= red_calc;
                    bslot_reg <= sk_reg[CW-1:0];
                    found_reg <= 1'b1;
                    bc_l_reg  <= cen_l_reg;
                    bc_a_reg  <= cen_a_reg;
                    bc_b_reg  <= cen_b_reg;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_best_slot_reg <= 8'(bslot_reg);
                    m_found_reg     <= found_reg;
                    m_cen_l_reg     <= bc_l_reg;
                    m_cen_a_reg     <= bc_a_reg;
                    m_cen_b_reg     <= bc_b_reg;
                    m_red_reg       <= bred_reg;
                    m_ovf_reg       <= ovf_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_best_slot       = m_best_slot_reg;
    assign m_found           = m_found_reg;
    assign m_centroid_l      = m_cen_l_reg;
    assign m_centroid_a      = m_cen_a_reg;
    assign m_centroid_b      = m_cen_b_reg;
    assign m_error_reduction = m_red_reg;
    assign m_overflow        = m_ovf_reg;

`ifndef SYNTHESIS
    // A new result only appears when the search has finished.
    a_result_after_search: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the search end");

    // The stored pixel count never passes capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PW+1)'(MAX_PIXELS))
        else $error("pixel count beyond capacity");

    // Slot 0 is never a winner.
    a_found_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> bslot_reg != '0)
        else $error("found set with slot zero");

    // The re-measure pipeline is drained before the reduction is taken.
    a_pix_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RED |-> !p1_vld_reg && !p2_vld_reg && !p3_vld_reg)
        else $error("reduction taken with pixels in flight");
`endif

endmodule
